FILE: rtl/stc_pkg.sv
// ----------------------------------------------------------------------------
// stc_pkg: shared types and constants of the swing tempo clock
// Field widths, register indexes, reset values and the controller/datapath
// command and status bundles.
// ----------------------------------------------------------------------------
package stc_pkg;

    // Position counter width and its saturation value
    localparam int POS_BITS = 32;
    localparam logic [POS_BITS-1:0] POS_MAX = '1;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int TEMPO_W = 17;
    localparam int RATE_W  = 18;
    localparam int DIV_W   = 7;
    localparam int SWING_W = 16;
    localparam int DEPTH_W = 15;
    localparam int BB_W    = 21;
    localparam int BEATS_W = 6;
    localparam int BEAT_W  = 5;
    localparam int R_W     = 18;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 18;
    localparam logic [CFG_IDX_W-1:0] REG_SYNC_MODE      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INTERNAL_TEMPO = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FRAME_RATE     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DIVISION_VALUE = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SWING_AMOUNT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_RANDOM_DEPTH   = 3'd5;

    // Sync modes
    localparam logic [MODE_W-1:0] MODE_FREE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_HOST  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_QUANT = 2'd2;

    // Divider operand widths
    localparam int NUM_W = 40;
    localparam int DEN_W = 30;
    localparam int CNT_W = 6;

    // Register reset values
    localparam logic [TEMPO_W-1:0] RST_TEMPO = 17'd30720;
    localparam logic [RATE_W-1:0]  RST_RATE  = 18'd48000;
    localparam logic [DIV_W-1:0]   RST_DIV   = 7'd4;

    // Period from the reset configuration
    localparam longint RST_Q = (64'd48000 * 64'd61440) / (64'd30720 * 64'd4);
    localparam logic [POS_BITS-1:0] RST_PERIOD = RST_Q[POS_BITS-1:0];
    localparam logic [POS_BITS-1:0] RST_HALF   = RST_PERIOD >> 1;

    // Tempo change threshold and bar edge thresholds
    localparam logic [TEMPO_W-1:0] TEMPO_STEP    = 17'd3;
    localparam logic [BB_W-1:0]    BAR_END_MIN   = 21'd64881;
    localparam logic [BB_W-1:0]    BAR_START_MAX = 21'd6553;

    // Constant factors
    localparam logic [3:0]  SYNC_MUL   = 4'd15;
    localparam logic [15:0] PERIOD_MUL = 16'd61440;

    // Jitter generator
    localparam logic [15:0] LFSR_SEED = 16'hACE1;
    localparam logic [15:0] LFSR_TAPS = 16'hB400;

    // Controller to datapath commands
    typedef struct packed {
        logic accept;
        logic sync_r;
        logic sync_m;
        logic sync_w;
        logic tempo;
        logic per_m;
        logic per_w;
        logic pre;
        logic mul;
        logic fire;
        logic inc;
        logic out_load;
    } stc_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic start_now;
        logic upd;
        logic qp;
        logic div_done;
        logic out_free;
    } stc_stat_t;

    // One step of the Galois LFSR
    function automatic logic [15:0] lfsr_next(input logic [15:0] v);
        logic [15:0] s;
        s = v >> 1;
        if (v[0])
        begin
            s = s ^ LFSR_TAPS;
        end
        return s;
    endfunction

endpackage

FILE: rtl/stc_div.sv
// ----------------------------------------------------------------------------
// stc_div: iterative unsigned divider
// Restoring division, one quotient bit per cycle; done pulses when the
// quotient is ready and the quotient holds until the next start.
// ----------------------------------------------------------------------------
module stc_div (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [stc_pkg::NUM_W-1:0] num,
    input  logic [stc_pkg::DEN_W-1:0] den,
    output logic                     done,
    output logic [stc_pkg::NUM_W-1:0] quot
);
    import stc_pkg::*;

    logic [NUM_W-1:0] dq_reg;
    logic [DEN_W:0]   rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             run_reg;
    logic             done_reg;
    logic [DEN_W:0]   trial;
    logic             qbit;
    logic [DEN_W:0]   rem_next;

    // Trial subtract of the shifted remainder
    always_comb
    begin
        trial    = {rem_reg[DEN_W-1:0], dq_reg[NUM_W-1]};
        qbit     = (trial >= {1'b0, den_reg});
        rem_next = qbit ? (trial - {1'b0, den_reg}) : trial;
    end

    // Control: iteration count and done pulse
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= run_reg && (cnt_reg == CNT_W'(1));
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CNT_W'(NUM_W);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    run_reg <= 1'b0;
                end
            end
        end
    end

    // Datapath: shift dividend out, quotient in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            dq_reg  <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (run_reg)
        begin
            dq_reg  <= {dq_reg[NUM_W-2:0], qbit};
            rem_reg <= rem_next;
        end
    end

    assign done = done_reg;
    assign quot = dq_reg;

endmodule

FILE: rtl/stc_dp.sv
// ----------------------------------------------------------------------------
// stc_dp: swing tempo clock datapath
// Configuration registers, clock state, sync and period arithmetic around
// the shared divider, swing trigger logic and the output register.
// ----------------------------------------------------------------------------
module stc_dp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  stc_pkg::stc_cmd_t             cmd,
    output stc_pkg::stc_stat_t            stat,
    input  logic                          cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          host_playing,
    input  logic [stc_pkg::TEMPO_W-1:0]    host_tempo,
    input  logic [stc_pkg::BB_W-1:0]       bar_beat,
    input  logic [stc_pkg::BEATS_W-1:0]    bar_beats,
    input  logic                          close_gate,
    input  logic                          out_stall,
    output logic                          out_valid,
    output logic                          gate_level,
    output logic                          gate_fired,
    output logic [stc_pkg::POS_BITS-1:0]   frame_position,
    output logic [stc_pkg::POS_BITS-1:0]   period_frames
);
    import stc_pkg::*;

    // Configuration registers
    logic [MODE_W-1:0]         mode_reg;
    logic [TEMPO_W-1:0]        itempo_reg;
    logic [RATE_W-1:0]         rate_reg;
    logic [DIV_W-1:0]          div_reg;
    logic signed [SWING_W-1:0] swing_reg;
    logic [DEPTH_W-1:0]        depth_reg;

    // Frame inputs
    logic               playing_reg;
    logic [TEMPO_W-1:0] host_reg;
    logic [BB_W-1:0]    bb_reg;
    logic [BEATS_W-1:0] beats_reg;

    // Clock state
    logic [POS_BITS-1:0] position_reg;
    logic [POS_BITS-1:0] period_reg;
    logic [POS_BITS-1:0] half_reg;
    logic [TEMPO_W-1:0]  bpm_reg;
    logic [TEMPO_W-1:0]  last_tempo_reg;
    logic [MODE_W-1:0]   last_mode_reg;
    logic [31:0]         bars_reg;
    logic [BEAT_W-1:0]   last_beat_reg;
    logic                bar_end_reg;
    logic                armed_reg;
    logic                slot_reg;
    logic                gate_reg;
    logic                was_playing_reg;
    logic [15:0]         lfsr_reg;

    // Working registers
    logic [R_W-1:0]      r_reg;
    logic signed [31:0]  prod_reg;
    logic [30:0]         fac_reg;
    logic [POS_BITS-1:0] trig_reg;
    logic                fired_reg;

    // Output register
    logic                out_valid_reg;
    logic                out_gate_reg;
    logic                out_fired_reg;
    logic [POS_BITS-1:0] out_pos_reg;
    logic [POS_BITS-1:0] out_per_reg;

    // Combinational values
    logic [TEMPO_W-1:0]      teff;
    logic [DIV_W-1:0]        deff;
    logic [TEMPO_W+DIV_W-1:0] td;
    logic [3:0]              bm;
    logic [R_W-1:0]          s18;
    logic [R_W+DIV_W-1:0]    r_full;
    logic [R_W-1:0]          r_next;
    logic [NUM_W-1:0]        sync_num;
    logic [NUM_W-1:0]        per_num;
    logic [NUM_W-1:0]        div_num;
    logic [DEN_W-1:0]        div_den;
    logic                    div_done;
    logic [NUM_W-1:0]        quot;
    logic [POS_BITS-1:0]     qsat;
    logic [TEMPO_W-1:0]      diff;
    logic                    upd;
    logic [TEMPO_W-1:0]      new_tempo;
    logic [BEAT_W-1:0]       beat;
    logic                    bar_inc;
    logic                    bar_end_next;
    logic                    last_beat_we;
    logic signed [31:0]      swing_ext;
    logic signed [31:0]      a_sum;
    logic signed [31:0]      a_clamp;
    logic signed [31:0]      fac_full;
    logic signed [31:0]      prod_next;
    logic [POS_BITS+30:0]    mul_full;
    logic                    slot_a;
    logic                    armed_a;
    logic [POS_BITS-1:0]     thr;
    logic                    fire;
    logic                    out_free;

    // Effective tempo and division, never zero
    assign teff = (bpm_reg == '0) ? TEMPO_W'(1) : bpm_reg;
    assign deff = (div_reg == '0) ? DIV_W'(1) : div_reg;
    assign td   = teff * deff;

    // Host time phase, reduced to the bits that survive the modulo
    always_comb
    begin
        bm       = bars_reg[1:0] * beats_reg[1:0];
        s18      = bb_reg[R_W-1:0] + {bm[1:0], 16'b0};
        r_full   = deff * s18;
        r_next   = r_full[R_W-1:0];
        sync_num = rate_reg * SYNC_MUL * r_reg;
        per_num  = rate_reg * PERIOD_MUL;
        div_num  = cmd.sync_m ? sync_num : per_num;
        div_den  = cmd.sync_m ? {td, 6'b0} : DEN_W'(td);
    end

    stc_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.sync_m || cmd.per_m),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (quot)
    );

    // Saturate the quotient to the position range
    assign qsat = (quot > NUM_W'(POS_MAX)) ? POS_MAX : quot[POS_BITS-1:0];

    // Tempo selection
    always_comb
    begin
        diff = (host_reg > last_tempo_reg) ? (host_reg - last_tempo_reg)
                                           : (last_tempo_reg - host_reg);
        upd = 1'b0;
        new_tempo = host_reg;
        if (mode_reg == MODE_FREE)
        begin
            upd = (itempo_reg != last_tempo_reg) || (last_mode_reg != MODE_FREE);
            new_tempo = itempo_reg;
        end
        else if (mode_reg == MODE_HOST || mode_reg == MODE_QUANT)
        begin
            upd = (diff >= TEMPO_STEP) || (last_mode_reg != mode_reg);
        end
    end

    // Bar counting
    always_comb
    begin
        beat         = bb_reg[BB_W-1:16];
        bar_inc      = 1'b0;
        bar_end_next = bar_end_reg;
        last_beat_we = 1'b0;
        if (beats_reg <= BEATS_W'(1))
        begin
            if (bb_reg >= BAR_END_MIN && !bar_end_reg)
            begin
                bar_end_next = 1'b1;
            end
            else if (bb_reg <= BAR_START_MAX && bar_end_reg)
            begin
                bar_inc      = 1'b1;
                bar_end_next = 1'b0;
            end
        end
        else if (beat != last_beat_reg)
        begin
            bar_inc      = (beat == '0);
            last_beat_we = 1'b1;
        end
    end

    // Swing offset, clamped to a quarter period either way
    always_comb
    begin
        prod_next = $signed({1'b0, depth_reg}) * $signed(lfsr_reg);
        swing_ext = {{2{swing_reg[SWING_W-1]}}, swing_reg, 14'b0};
        a_sum     = swing_ext + prod_reg;
        if (a_sum > 32'sh2000_0000)
        begin
            a_clamp = 32'sh2000_0000;
        end
        else if (a_sum < -32'sh2000_0000)
        begin
            a_clamp = -32'sh2000_0000;
        end
        else
        begin
            a_clamp = a_sum;
        end
        fac_full = a_clamp + 32'sh4000_0000;
        mul_full = half_reg * fac_reg;
    end

    // Trigger decision
    always_comb
    begin
        slot_a  = slot_reg;
        armed_a = armed_reg;
        if (position_reg < trig_reg && armed_reg)
        begin
            slot_a  = !slot_reg;
            armed_a = 1'b0;
        end
        thr  = slot_a ? trig_reg : '0;
        fire = (position_reg >= thr) && !armed_a;
    end

    assign out_free = !out_valid_reg || !out_stall;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_FREE;
            itempo_reg <= RST_TEMPO;
            rate_reg   <= RST_RATE;
            div_reg    <= RST_DIV;
            swing_reg  <= '0;
            depth_reg  <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SYNC_MODE:      mode_reg   <= cfg_data[MODE_W-1:0];
                REG_INTERNAL_TEMPO: itempo_reg <= cfg_data[TEMPO_W-1:0];
                REG_FRAME_RATE:     rate_reg   <= cfg_data[RATE_W-1:0];
                REG_DIVISION_VALUE: div_reg    <= cfg_data[DIV_W-1:0];
                REG_SWING_AMOUNT:   swing_reg  <= cfg_data[SWING_W-1:0];
                REG_RANDOM_DEPTH:   depth_reg  <= cfg_data[DEPTH_W-1:0];
                default:            ;
            endcase
        end
    end

    // Clock state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            position_reg    <= '0;
            period_reg      <= RST_PERIOD;
            half_reg        <= RST_HALF;
            bpm_reg         <= RST_TEMPO;
            last_tempo_reg  <= '0;
            last_mode_reg   <= MODE_FREE;
            last_beat_reg   <= '0;
            bar_end_reg     <= 1'b0;
            armed_reg       <= 1'b0;
            slot_reg        <= 1'b0;
            gate_reg        <= 1'b0;
            was_playing_reg <= 1'b0;
            lfsr_reg        <= LFSR_SEED;
        end
        else
        begin
            // Clear the gate and note the transport edge on transfer
            if (cmd.accept)
            begin
                if (close_gate)
                begin
                    gate_reg <= 1'b0;
                end
                was_playing_reg <= host_playing;
            end
            // Bars and tempo
            if (cmd.tempo)
            begin
                bar_end_reg <= bar_end_next;
                if (last_beat_we)
                begin
                    last_beat_reg <= beat;
                end
                if (upd)
                begin
                    bpm_reg        <= new_tempo;
                    last_tempo_reg <= new_tempo;
                    last_mode_reg  <= mode_reg;
                end
            end
            if (cmd.per_w)
            begin
                half_reg   <= qsat >> 1;
                period_reg <= (qsat == '0) ? POS_BITS'(1) : qsat;
            end
            // Position updates
            if (cmd.sync_w)
            begin
                position_reg <= qsat;
            end
            else if (cmd.pre && position_reg > period_reg)
            begin
                position_reg <= '0;
            end
            else if (cmd.inc)
            begin
                position_reg <= position_reg + POS_BITS'(1);
            end
            // Trigger
            if (cmd.fire)
            begin
                slot_reg  <= slot_a;
                armed_reg <= armed_a || fire;
                if (fire)
                begin
                    lfsr_reg <= lfsr_next(lfsr_reg);
                    gate_reg <= 1'b1;
                end
            end
        end
    end

    // Bar counter, wraps at 32 bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bars_reg <= '0;
        end
        else if (cmd.tempo && bar_inc)
        begin
            bars_reg <= bars_reg + 32'd1;
        end
    end

    // Frame inputs and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            playing_reg <= host_playing;
            host_reg    <= host_tempo;
            bb_reg      <= bar_beat;
            beats_reg   <= bar_beats;
        end
        if (cmd.sync_r)
        begin
            r_reg <= r_next;
        end
        if (cmd.tempo)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.pre)
        begin
            fac_reg <= fac_full[30:0];
        end
        if (cmd.mul)
        begin
            trig_reg <= mul_full[POS_BITS+29:30];
        end
        if (cmd.fire)
        begin
            fired_reg <= fire;
        end
        if (cmd.out_load)
        begin
            out_gate_reg  <= gate_reg;
            out_fired_reg <= fired_reg;
            out_pos_reg   <= position_reg;
            out_per_reg   <= period_reg;
        end
    end

    // Output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Status
    always_comb
    begin
        stat.start_now = host_playing && !was_playing_reg && (mode_reg == MODE_QUANT);
        stat.upd       = upd;
        stat.qp        = playing_reg && (mode_reg == MODE_QUANT);
        stat.div_done  = div_done;
        stat.out_free  = out_free;
    end

    assign out_valid      = out_valid_reg;
    assign gate_level     = out_gate_reg;
    assign gate_fired     = out_fired_reg;
    assign frame_position = out_pos_reg;
    assign period_frames  = out_per_reg;

endmodule

FILE: rtl/stc_ctrl.sv
// ----------------------------------------------------------------------------
// stc_ctrl: swing tempo clock sequencer
// Steps one frame through sync, tempo, a period recompute on a tempo change,
// trigger and output, and runs the period recompute after a rate or division write.
// ----------------------------------------------------------------------------
module stc_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               cfg_we,
    input  logic               cfg_kick,
    input  stc_pkg::stc_stat_t stat,
    output stc_pkg::stc_cmd_t  cmd,
    output logic               in_stall
);
    import stc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SYR   = 4'd1;
    localparam logic [3:0] ST_SYM   = 4'd2;
    localparam logic [3:0] ST_SYW   = 4'd3;
    localparam logic [3:0] ST_TEMPO = 4'd4;
    localparam logic [3:0] ST_PERM  = 4'd5;
    localparam logic [3:0] ST_PERW  = 4'd6;
    localparam logic [3:0] ST_PRE   = 4'd7;
    localparam logic [3:0] ST_MUL   = 4'd8;
    localparam logic [3:0] ST_FIRE  = 4'd9;
    localparam logic [3:0] ST_FIN   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic [3:0] ret_reg;
    logic [3:0] ret_next;
    logic       frame_reg;
    logic       frame_next;
    logic       pend_reg;
    logic       pend_next;
    logic       open;

    assign open     = (state_reg == ST_IDLE) && !pend_reg && !cfg_we;
    assign in_stall = !open;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        ret_next   = ret_reg;
        frame_next = frame_reg;
        pend_next  = pend_reg || cfg_kick;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (pend_reg)
                begin
                    pend_next  = cfg_kick;
                    frame_next = 1'b0;
                    state_next = ST_PERM;
                end
                else if (open && in_valid)
                begin
                    cmd.accept = 1'b1;
                    if (stat.start_now)
                    begin
                        ret_next   = ST_TEMPO;
                        state_next = ST_SYR;
                    end
                    else
                    begin
                        state_next = ST_TEMPO;
                    end
                end
            end
            ST_SYR:
            begin
                cmd.sync_r = 1'b1;
                state_next = ST_SYM;
            end
            ST_SYM:
            begin
                cmd.sync_m = 1'b1;
                state_next = ST_SYW;
            end
            ST_SYW:
            begin
                if (stat.div_done)
                begin
                    cmd.sync_w = 1'b1;
                    state_next = ret_reg;
                end
            end
            ST_TEMPO:
            begin
                cmd.tempo = 1'b1;
                if (stat.upd)
                begin
                    frame_next = 1'b1;
                    state_next = ST_PERM;
                end
                else
                begin
                    state_next = ST_PRE;
                end
            end
            ST_PERM:
            begin
                cmd.per_m  = 1'b1;
                state_next = ST_PERW;
            end
            ST_PERW:
            begin
                if (stat.div_done)
                begin
                    cmd.per_w = 1'b1;
                    if (!frame_reg)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (stat.qp)
                    begin
                        ret_next   = ST_PRE;
                        state_next = ST_SYR;
                    end
                    else
                    begin
                        state_next = ST_PRE;
                    end
                end
            end
            ST_PRE:
            begin
                cmd.pre    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = ST_FIRE;
            end
            ST_FIRE:
            begin
                cmd.fire   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (stat.qp)
                begin
                    ret_next   = ST_OUT;
                    state_next = ST_SYR;
                end
                else
                begin
                    cmd.inc    = 1'b1;
                    state_next = ST_OUT;
                end
            end
            ST_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold sequencer state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ret_reg   <= ST_IDLE;
            frame_reg <= 1'b0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            frame_reg <= frame_next;
            pend_reg  <= pend_next;
        end
    end

endmodule

FILE: rtl/swing_tempo_clock.sv
// ----------------------------------------------------------------------------
// swing_tempo_clock: tempo clock divider with swing and timing jitter
// Takes one host transport frame per transfer and returns one gate result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one audio frame of host state.
//   Output channel (out_valid/out_stall) returns one result per frame: the
//   gate level, whether it fired, the position and the current period.
//   Configuration is a plain write port (cfg_we, cfg_index, cfg_data), to
//   be used only while the block is idle, which the block does not enforce.
//   A frame rate or division write stalls input for a period recompute.
// Frame processing:
//   A frame runs its tempo, trigger and output steps, plus a division on
//   the shared 40-bit restoring divider for each of: a position sync on
//   transport start and a sync at the end of the frame, both in quantized
//   play, a period recompute on a tempo change and, in quantized play, a
//   sync after that recompute.
//   One frame is in work at a time.
// Reset:
//   All control state clears; tempo is 120 bpm, period 24000 frames.
// Stall:
//   A result waits in the output register; the next frame is taken and
//   worked on, and its result waits until the register is taken.
// ----------------------------------------------------------------------------
module swing_tempo_clock (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          host_playing,
    input  logic [stc_pkg::TEMPO_W-1:0]    host_tempo,
    input  logic [stc_pkg::BB_W-1:0]       bar_beat,
    input  logic [stc_pkg::BEATS_W-1:0]    bar_beats,
    input  logic                          close_gate,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          gate_level,
    output logic                          gate_fired,
    output logic [stc_pkg::POS_BITS-1:0]   frame_position,
    output logic [stc_pkg::POS_BITS-1:0]   period_frames,
    input  logic                          cfg_we,
    input  logic [stc_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [stc_pkg::CFG_DATA_W-1:0] cfg_data
);
    import stc_pkg::*;

    stc_cmd_t  cmd;
    stc_stat_t stat;
    logic      cfg_kick;

    // Rate and division writes need a new period
    assign cfg_kick = cfg_we &&
                      (cfg_index == REG_FRAME_RATE || cfg_index == REG_DIVISION_VALUE);

    stc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .cfg_we   (cfg_we),
        .cfg_kick (cfg_kick),
        .stat     (stat),
        .cmd      (cmd),
        .in_stall (in_stall)
    );

    stc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .host_playing   (host_playing),
        .host_tempo     (host_tempo),
        .bar_beat       (bar_beat),
        .bar_beats      (bar_beats),
        .close_gate     (close_gate),
        .out_stall      (out_stall),
        .out_valid      (out_valid),
        .gate_level     (gate_level),
        .gate_fired     (gate_fired),
        .frame_position (frame_position),
        .period_frames  (period_frames)
    );

    // A transfer in starts a frame, so the next cycle is busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input taken while a frame is in work");

    // A fired trigger always leaves the gate set
    a_fired_sets_gate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (!gate_fired || gate_level))
        else $error("trigger fired without gate");

    // The period is never zero
    a_period_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (period_frames != '0))
        else $error("zero period reported");

endmodule

FILE: verif/swing_tempo_clock_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swing_tempo_clock_tb: self-checking bench for the swing tempo clock
// Sends host transport frames under several register settings and idle
// patterns, predicts every gate result in a local model of the clock and
// compares each result transfer field by field in arrival order.
// ----------------------------------------------------------------------------
module swing_tempo_clock_tb;
    import stc_pkg::*;

    typedef struct packed {
        logic        level;
        logic        fired;
        logic [31:0] pos;
        logic [31:0] per;
    } gate_result_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    logic host_playing;
    logic [TEMPO_W-1:0] host_tempo;
    logic [BB_W-1:0] bar_beat;
    logic [BEATS_W-1:0] bar_beats;
    logic close_gate;
    logic out_valid;
    logic out_stall;
    logic gate_level;
    logic gate_fired;
    logic [31:0] frame_position;
    logic [31:0] period_frames;
    logic cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    swing_tempo_clock uut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall),
        .host_playing(host_playing), .host_tempo(host_tempo),
        .bar_beat(bar_beat), .bar_beats(bar_beats), .close_gate(close_gate),
        .out_valid(out_valid), .out_stall(out_stall),
        .gate_level(gate_level), .gate_fired(gate_fired),
        .frame_position(frame_position), .period_frames(period_frames),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    // Clock: 20 ns period
    initial clk = 1'b0;
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Local copy of the clock state and registers
    logic [1:0]  m_mode;
    logic [16:0] m_int_tempo;
    logic [17:0] m_rate;
    logic [6:0]  m_div;
    logic signed [15:0] m_swing;
    logic [14:0] m_depth;
    logic [31:0] m_pos, m_per, m_half;
    logic [16:0] m_bpm, m_last_tempo;
    logic [1:0]  m_last_mode;
    logic [31:0] m_bars;
    logic [4:0]  m_last_beat;
    logic m_bar_end, m_armed, m_slot, m_gate, m_was_playing;
    logic signed [15:0] m_jitter;
    logic [15:0] m_lfsr;

    gate_result_t gate_expected[$];
    int mismatches;
    int stall_pct;
    int idle_pct;
    bit hold_off;
    longint cycles;

    function automatic logic [63:0] eff(input logic [63:0] v);
        return (v == 0) ? 64'd1 : v;
    endfunction

    task automatic recalc_period();
        logic [63:0] q;
        q = (64'(m_rate) * 64'd61440) / (eff(64'(m_bpm)) * eff(64'(m_div)));
        if (q > 64'hFFFF_FFFF)
        begin
            q = 64'hFFFF_FFFF;
        end
        m_half = q[32:1];
        m_per = (q == 0) ? 32'd1 : q[31:0];
    endtask

    task automatic hard_sync(input logic [20:0] bb, input logic [5:0] beats);
        logic [63:0] s, r, p;
        s = 64'(bb) + 64'(m_bars) * 64'(beats) * 64'd65536;
        r = (eff(64'(m_div)) * s) & 64'h3FFFF;
        p = (64'(m_rate) * 64'd15 * r) / (eff(64'(m_bpm)) * eff(64'(m_div)) * 64'd64);
        m_pos = (p > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : p[31:0];
    endtask

    task automatic clock_reset();
        m_mode = MODE_FREE; m_int_tempo = RST_TEMPO; m_rate = RST_RATE;
        m_div = RST_DIV; m_swing = 0; m_depth = 0;
        m_pos = 0; m_bpm = RST_TEMPO; m_last_tempo = 0; m_last_mode = 0;
        m_bars = 0; m_last_beat = 0;
        m_bar_end = 0; m_armed = 0; m_slot = 0; m_gate = 0; m_was_playing = 0;
        m_lfsr = LFSR_SEED; m_jitter = LFSR_SEED;
        recalc_period();
    endtask

    // Advance the clock model by one frame and queue its result
    task automatic predict_frame(input logic play, input logic [16:0] host,
                                 input logic [20:0] bb, input logic [5:0] beats,
                                 input logic clr);
        logic quant, fired, lsb;
        logic [4:0] beat;
        logic [16:0] diff;
        longint a, num;
        logic [31:0] trig1;
        gate_result_t res;
        quant = (m_mode == MODE_QUANT);
        fired = 0;
        if (clr)
        begin
            m_gate = 0;
        end
        if (play && !m_was_playing && quant)
        begin
            hard_sync(bb, beats);
        end
        m_was_playing = play;

        // Bar counting
        beat = bb[20:16];
        if (beats <= 1)
        begin
            if (bb >= BAR_END_MIN && !m_bar_end)
            begin
                m_bar_end = 1;
            end
            else if (bb <= BAR_START_MAX && m_bar_end)
            begin
                m_bars++;
                m_bar_end = 0;
            end
        end
        else if (beat != m_last_beat)
        begin
            if (beat == 0)
            begin
                m_bars++;
            end
            m_last_beat = beat;
        end

        // Tempo pick
        diff = (host > m_last_tempo) ? host - m_last_tempo : m_last_tempo - host;
        if (m_mode == MODE_FREE)
        begin
            if (m_int_tempo != m_last_tempo || m_last_mode != MODE_FREE)
            begin
                m_bpm = m_int_tempo; recalc_period();
                m_last_tempo = m_int_tempo; m_last_mode = MODE_FREE;
            end
        end
        else if (m_mode == MODE_HOST || m_mode == MODE_QUANT)
        begin
            if (diff >= TEMPO_STEP || m_last_mode != m_mode)
            begin
                m_bpm = host; recalc_period();
                if (quant && play)
                begin
                    hard_sync(bb, beats);
                end
                m_last_tempo = host; m_last_mode = m_mode;
            end
        end

        if (m_pos > m_per)
        begin
            m_pos = 0;
        end

        // Swung second trigger
        a = longint'(m_swing) * 16384 + longint'(m_depth) * longint'(m_jitter);
        if (a > (64'sd1 <<< 29))
        begin
            a = 64'sd1 <<< 29;
        end
        if (a < -(64'sd1 <<< 29))
        begin
            a = -(64'sd1 <<< 29);
        end
        num = longint'(m_half) * ((64'sd1 <<< 30) + a);
        trig1 = 32'(num >>> 30);

        if (m_pos < trig1 && m_armed)
        begin
            m_slot = !m_slot; m_armed = 0;
        end
        if (m_pos >= (m_slot ? trig1 : 32'd0) && !m_armed)
        begin
            lsb = m_lfsr[0];
            m_lfsr = m_lfsr >> 1;
            if (lsb)
            begin
                m_lfsr = m_lfsr ^ LFSR_TAPS;
            end
            m_jitter = m_lfsr;
            m_gate = 1; m_armed = 1; fired = 1;
        end

        if (play && quant)
        begin
            hard_sync(bb, beats);
        end
        else
        begin
            m_pos = m_pos + 1;
        end
        res.level = m_gate; res.fired = fired; res.pos = m_pos; res.per = m_per;
        gate_expected.push_back(res);
    endtask

    // Send one frame and predict its result once the transfer happens
    task automatic send_frame(input logic play, input logic [16:0] host,
                              input logic [20:0] bb, input logic [5:0] beats,
                              input logic clr);
        // Leave the previous drop of valid its own falling edge
        @(negedge clk);
        while (idle_pct > 0 && $urandom_range(99) < idle_pct)
        begin
            @(negedge clk);
        end
        in_valid <= 1'b1;
        host_playing <= play; host_tempo <= host; bar_beat <= bb;
        bar_beats <= beats; close_gate <= clr;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        predict_frame(play, host, bb, beats, clr);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic drain();
        while (gate_expected.size() != 0)
        begin
            @(negedge clk);
        end
        repeat (200) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [17:0] val);
        cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_SYNC_MODE:      m_mode = val[1:0];
            REG_INTERNAL_TEMPO: m_int_tempo = val[16:0];
            REG_FRAME_RATE:     begin m_rate = val; recalc_period(); end
            REG_DIVISION_VALUE: begin m_div = val[6:0]; recalc_period(); end
            REG_SWING_AMOUNT:   m_swing = val[15:0];
            REG_RANDOM_DEPTH:   m_depth = val[14:0];
            default: ;
        endcase
        repeat (60) @(negedge clk);
    endtask

    task automatic write_all(input logic [1:0] mode, input logic [16:0] tempo,
                             input logic [17:0] rate, input logic [6:0] dv,
                             input logic [15:0] sw, input logic [14:0] dp);
        drain();
        write_reg(REG_SYNC_MODE, mode);
        write_reg(REG_INTERNAL_TEMPO, tempo);
        write_reg(REG_FRAME_RATE, rate);
        write_reg(REG_DIVISION_VALUE, dv);
        write_reg(REG_SWING_AMOUNT, sw);
        write_reg(REG_RANDOM_DEPTH, dp);
    endtask

    // Result checker
    always @(posedge clk)
    begin
        gate_result_t e;
        if (rst_n && out_valid && !out_stall)
        begin
            if (gate_expected.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected result transfer pos=%0d", frame_position);
                end
            end
            else
            begin
                e = gate_expected.pop_front();
                if (e.level !== gate_level || e.fired !== gate_fired ||
                    e.pos !== frame_position || e.per !== period_frames)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("mismatch exp lvl=%0d fire=%0d pos=%0d per=%0d",
                                 e.level, e.fired, e.pos, e.per);
                        $display("         got lvl=%0d fire=%0d pos=%0d per=%0d",
                                 gate_level, gate_fired, frame_position, period_frames);
                    end
                end
            end
        end
    end

    // Receiver stall
    always @(negedge clk)
    begin
        out_stall <= hold_off || (stall_pct > 0 && $urandom_range(99) < stall_pct);
    end

    // Run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > 3000000)
        begin
            $display("swing_tempo_clock_tb NOT OK");
            $finish;
        end
    end

    // Random frame: mostly steady playback with a walking bar position
    logic [20:0] walk_bb;
    logic [16:0] walk_tempo;

    task automatic random_frames(input int n);
        logic [5:0] beats;
        logic [16:0] t;
        for (int i = 0; i < n; i++)
        begin
            beats = ($urandom_range(9) == 0) ? 6'($urandom_range(63)) :
                    6'($urandom_range(1, 8));
            if (beats == 0) beats = 1;
            walk_bb = walk_bb + 21'($urandom_range(20000));
            if (walk_bb[20:16] >= beats)
            begin
                walk_bb = 21'($urandom_range(6000));
            end
            if ($urandom_range(19) == 0)
            begin
                walk_tempo = 17'($urandom_range(256, 76800));
            end
            t = walk_tempo + 17'($urandom_range(4)) - 17'd2;
            if ($urandom_range(15) == 0)
            begin
                send_frame($urandom_range(1), 17'($urandom), 21'($urandom),
                           6'($urandom), $urandom_range(1));
            end
            else
            begin
                send_frame($urandom_range(15) != 0, t, walk_bb, beats,
                           $urandom_range(3) == 0);
            end
        end
    endtask

    task automatic test_directed();
        send_frame(0, 17'd30720, 21'd0, 6'd4, 0);
        send_frame(1, 17'd30720, 21'd0, 6'd4, 0);
        send_frame(1, 17'd76800, 21'h1FFFFF, 6'd63, 1);
        send_frame(1, 17'd0, 21'd0, 6'd0, 0);
        send_frame(0, 17'h1FFFF, 21'd64881, 6'd1, 1);
        send_frame(0, 17'd256, 21'd6553, 6'd1, 0);
        send_frame(1, 17'd30721, 21'd65536, 6'd4, 0);
        write_all(MODE_HOST, 17'd0, 18'd8000, 7'd64, 16'h7FFF, 15'h7FFF);
        send_frame(1, 17'd256, 21'd0, 6'd4, 0);
        send_frame(1, 17'd258, 21'd0, 6'd4, 0);
        send_frame(1, 17'd76800, 21'd100, 6'd4, 1);
        write_all(MODE_QUANT, 17'd76800, 18'h3FFFF, 7'd0, 16'h8000, 15'd0);
        send_frame(0, 17'd256, 21'd0, 6'd2, 0);
        send_frame(1, 17'd256, 21'd70000, 6'd2, 0);
        send_frame(1, 17'd76800, 21'h1FFFFF, 6'd2, 1);
        send_frame(1, 17'd0, 21'd0, 6'd32, 0);
        write_all(2'd3, 17'd256, 18'd192000, 7'd127, 16'd0, 15'd100);
        send_frame(1, 17'd1000, 21'd0, 6'd4, 0);
        send_frame(0, 17'd2000, 21'd0, 6'd4, 1);
        write_all(MODE_FREE, 17'd76800, 18'd0, 7'd1, 16'd0, 15'd0);
        send_frame(1, 17'd1000, 21'd0, 6'd4, 0);
        send_frame(1, 17'd1000, 21'd0, 6'd4, 0);
    endtask

    task automatic test_settings();
        logic [1:0] modes[4] = '{MODE_FREE, MODE_HOST, MODE_QUANT, MODE_QUANT};
        for (int ph = 0; ph < 8; ph++)
        begin
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 45; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 45; end
                default: begin idle_pct = 22; stall_pct = 22; end
            endcase
            write_all(modes[ph % 4], 17'($urandom_range(256, 76800)),
                      18'($urandom_range(8000, 192000)), 7'($urandom_range(1, 64)),
                      16'($urandom), 15'($urandom));
            random_frames(180);
        end
        idle_pct = 0; stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_all(MODE_FREE, 17'd30720, 18'd48000, 7'd16, 16'd4000, 15'd2000);
        fork
            begin
                hold_off = 1;
                repeat (400) @(negedge clk);
                hold_off = 0;
            end
            random_frames(30);
        join
        drain();
        random_frames(20);
    endtask

    initial
    begin
        rst_n = 0; in_valid = 0; out_stall = 0; cfg_we = 0; cfg_index = 0;
        cfg_data = 0; host_playing = 0; host_tempo = 0; bar_beat = 0;
        bar_beats = 0; close_gate = 0;
        mismatches = 0; stall_pct = 0; idle_pct = 0; hold_off = 0; cycles = 0;
        walk_bb = 0; walk_tempo = 17'd30720;
        clock_reset();
        repeat (12) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        test_directed();
        test_settings();
        test_backpressure();
        drain();
        if (mismatches == 0 && gate_expected.size() == 0)
        begin
            $display("swing_tempo_clock_tb OK");
        end
        else
        begin
            $display("swing_tempo_clock_tb NOT OK");
        end
        $finish;
    end
endmodule

FILE: swing_tempo_clock.f
rtl/stc_pkg.sv
rtl/stc_div.sv
rtl/stc_dp.sv
rtl/stc_ctrl.sv
rtl/swing_tempo_clock.sv
verif/swing_tempo_clock_tb.sv
